### rtl/ttl_pkg.sv
// Shared types, constants and character tables for the template text lexer.
`timescale 1ns / 1ps
package ttl_pkg;

    localparam int unsigned IQ_DEPTH = 2;
    localparam int unsigned IQ_AW    = $clog2(IQ_DEPTH);
    localparam int unsigned IQ_CW    = $clog2(IQ_DEPTH + 1);
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
    localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

    localparam int unsigned APB_AW = 3;
    localparam int unsigned REG_AW = APB_AW - 2;
    localparam logic [REG_AW-1:0] REG_SIGN_CHAR = '0;

    localparam logic [7:0] SIGN_RESET = 8'd35;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_NL      = 8'h0a;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;

    typedef enum logic [3:0] {
        K_WORD  = 4'd0,
        K_STRING = 4'd1,
        K_LABEL = 4'd2,
        K_SIGN  = 4'd3,
        K_STOP  = 4'd4,
        K_START = 4'd5,
        K_STOB  = 4'd6,
        K_STARB = 4'd7,
        K_END   = 4'd8
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_SLASH   = 4'd1,
        M_COMMENT = 4'd2,
        M_WORD    = 4'd3,
        M_STRING  = 4'd4,
        M_ESCAPE  = 4'd5,
        M_LABEL   = 4'd6,
        M_MATCH   = 4'd7,
        M_SWALLOW = 4'd8,
        M_STOPPED = 4'd9
    } t_mode;

    typedef enum logic [1:0] {
        S_RUN    = 2'd0,
        S_REPLAY = 2'd1,
        S_END    = 2'd2
    } t_seq;

    typedef struct packed {
        logic alnum;
        logic alpha;
    } t_cls;

    typedef struct packed {
        logic       flush;
        logic [7:0] ch;
        t_cls       cls;
    } t_word;

    typedef struct packed {
        logic  avail;
        t_word word;
    } t_head;

    typedef struct packed {
        logic [7:0] ch;
        t_kind      kind;
        logic       last;
        logic       empty;
    } t_res;

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        c.alpha = ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));
        c.alnum = c.alpha || ((b >= 8'h30) && (b <= 8'h39));
        return c;
    endfunction

    function automatic logic [3:0] dir_len(input logic [1:0] br);
        return br[0] ? 4'd10 : 4'd9;
    endfunction

    // length of the shared prefix of two directives
    function automatic logic [3:0] dir_common(input logic [1:0] a, input logic [1:0] b);
        logic [3:0] n;
        if (a == b) begin
            n = dir_len(a);
        end else if ((a[0] == b[0]) && a[0]) begin
            n = 4'd9;
        end else if (a[0] == b[0]) begin
            n = 4'd8;
        end else begin
            n = 4'd7;
        end
        return n;
    endfunction

    function automatic logic [7:0] dir_char(input logic [1:0] br, input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0: c = CH_HASH;
            4'd1: c = 8'h63;
            4'd2: c = 8'h78;
            4'd3: c = 8'h79;
            4'd4: c = 8'h20;
            4'd5: c = 8'h73;
            4'd6: c = 8'h74;
            4'd7: c = br[0] ? 8'h61 : 8'h6f;
            4'd8: begin
                unique case (br)
                    2'd0: c = 8'h70;
                    2'd2: c = 8'h62;
                    default: c = 8'h72;
                endcase
            end
            4'd9: begin
                unique case (br)
                    2'd1: c = 8'h74;
                    2'd3: c = 8'h62;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### rtl/ttl_front.sv
// Input queue: accepts text words and classifies each byte on entry.
`timescale 1ns / 1ps
module ttl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic            i_action,
    input  logic [7:0]      i_text_byte,
    output logic            o_full,
    input  logic            i_pop,
    output ttl_pkg::t_head  o_head
);
    import ttl_pkg::*;

    t_word              r_mem [IQ_DEPTH];
    logic [IQ_AW-1:0]   r_wp;
    logic [IQ_AW-1:0]   r_rp;
    logic [IQ_CW-1:0]   r_cnt;
    logic               w_wr;
    logic               w_rd;
    t_word              w_in;

    assign o_full = (r_cnt == IQ_CW'(IQ_DEPTH));
    assign w_wr   = i_push && !o_full;
    assign w_rd   = i_pop && (r_cnt != '0);

    always_comb begin
        w_in.flush = i_action;
        w_in.ch    = i_text_byte;
        w_in.cls   = classify(i_text_byte);
    end

    assign o_head.avail = (r_cnt != '0);
    assign o_head.word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_wr && w_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_in;
        end
    end

endmodule

### rtl/ttl_back.sv
// Lexer engine: runs the token state machine, directive match and replay.
`timescale 1ns / 1ps
module ttl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_sign_char,
    input  ttl_pkg::t_head  i_head,
    output logic            o_pop,
    output logic            o_wr,
    output ttl_pkg::t_res   o_res,
    input  logic            i_oq_full
);
    import ttl_pkg::*;

    t_seq       r_seq,          n_seq;
    t_mode      r_mode,         n_mode;
    logic [3:0] r_match_count,  n_match_count;
    logic [1:0] r_match_branch, n_match_branch;
    logic [7:0] r_held_char,    n_held_char;
    t_kind      r_held_kind,    n_held_kind;
    logic       r_held_valid,   n_held_valid;
    logic [3:0] r_rep_idx,      n_rep_idx;

    logic [7:0] w_b;
    t_cls       w_cls;
    logic       w_idle_go;
    t_mode      p_mode;
    t_kind      p_kind;
    logic [7:0] p_char;
    logic       p_valid;
    logic [3:0] p_cnt;
    logic [1:0] p_br;
    logic       p_emit;
    t_res       p_res;
    logic       m_hit;
    logic [1:0] m_j;
    logic       m_done;
    t_res       w_sign_res;
    t_res       w_end_res;
    t_res       w_close_res;

    assign w_b   = (r_seq == S_REPLAY) ? dir_char(r_match_branch, r_rep_idx)
                                       : i_head.word.ch;
    assign w_cls = (r_seq == S_REPLAY) ? classify(w_b) : i_head.word.cls;

    assign w_sign_res  = '{ch: CH_HASH, kind: K_SIGN, last: 1'b1, empty: 1'b0};
    assign w_end_res   = '{ch: 8'h00, kind: K_END, last: 1'b1, empty: 1'b1};

    always_comb begin
        if (r_held_valid) begin
            w_close_res = '{ch: r_held_char, kind: r_held_kind, last: 1'b1, empty: 1'b0};
        end else begin
            w_close_res = '{ch: 8'h00, kind: r_held_kind, last: 1'b1, empty: 1'b1};
        end
    end

    // one byte through every mode but an open directive match
    always_comb begin
        p_mode    = r_mode;
        p_kind    = r_held_kind;
        p_char    = r_held_char;
        p_valid   = r_held_valid;
        p_cnt     = r_match_count;
        p_br      = r_match_branch;
        p_emit    = 1'b0;
        p_res     = w_sign_res;
        w_idle_go = 1'b0;
        unique case (r_mode)
            M_SLASH: begin
                if (w_b == CH_SLASH) begin
                    p_mode = M_COMMENT;
                end else begin
                    p_emit    = (i_sign_char == CH_SLASH);
                    w_idle_go = 1'b1;
                end
            end
            M_COMMENT: begin
                w_idle_go = (w_b == CH_NL);
            end
            M_WORD, M_LABEL: begin
                if ((r_mode == M_WORD) ? w_cls.alnum : w_cls.alpha) begin
                    p_emit  = r_held_valid;
                    p_res   = '{ch: r_held_char, kind: r_held_kind, last: 1'b0, empty: 1'b0};
                    p_char  = w_b;
                    p_valid = 1'b1;
                end else begin
                    p_emit  = 1'b1;
                    p_res   = w_close_res;
                    p_valid = 1'b0;
                    p_mode  = M_IDLE;
                end
            end
            M_STRING, M_ESCAPE: begin
                if ((r_mode == M_STRING) && (w_b == CH_QUOTE)) begin
                    p_emit  = 1'b1;
                    p_res   = w_close_res;
                    p_valid = 1'b0;
                    p_mode  = M_IDLE;
                end else begin
                    p_emit  = r_held_valid;
                    p_res   = '{ch: r_held_char, kind: r_held_kind, last: 1'b0, empty: 1'b0};
                    p_char  = w_b;
                    p_valid = 1'b1;
                    p_mode  = ((r_mode == M_STRING) && (w_b == CH_BSLASH)) ? M_ESCAPE
                                                                          : M_STRING;
                end
            end
            M_SWALLOW: begin
                p_mode = M_IDLE;
            end
            M_STOPPED: begin
                p_mode = M_STOPPED;
            end
            default: begin
                w_idle_go = 1'b1;
            end
        endcase
        if (w_idle_go) begin
            p_mode = M_IDLE;
            priority if (w_b == CH_SLASH) begin
                p_mode = M_SLASH;
            end else if (w_cls.alnum) begin
                p_kind  = K_WORD;
                p_mode  = M_WORD;
                p_char  = w_b;
                p_valid = 1'b1;
            end else if (w_b == CH_QUOTE) begin
                p_kind  = K_STRING;
                p_mode  = M_STRING;
                p_valid = 1'b0;
            end else if (w_b == i_sign_char) begin
                if (w_b == CH_HASH) begin
                    p_mode = M_MATCH;
                    p_cnt  = 4'd1;
                    p_br   = 2'd0;
                end else begin
                    p_emit = 1'b1;
                    p_res  = w_sign_res;
                end
            end else if (w_b == CH_COLON) begin
                p_kind  = K_LABEL;
                p_mode  = M_LABEL;
                p_char  = w_b;
                p_valid = 1'b1;
            end else begin
                p_mode = M_IDLE;
            end
        end
    end

    // first directive that extends the current prefix with this byte
    always_comb begin
        m_hit = 1'b0;
        m_j   = 2'd0;
        for (int j = 3; j >= 0; j--) begin
            if ((r_match_count < dir_len(2'(j))) &&
                (r_match_count <= dir_common(2'(j), r_match_branch)) &&
                (dir_char(2'(j), r_match_count) == i_head.word.ch)) begin
                m_hit = 1'b1;
                m_j   = 2'(j);
            end
        end
        m_done = ((r_match_count + 4'd1) == dir_len(m_j));
    end

    always_comb begin
        n_seq          = r_seq;
        n_mode         = r_mode;
        n_match_count  = r_match_count;
        n_match_branch = r_match_branch;
        n_held_char    = r_held_char;
        n_held_kind    = r_held_kind;
        n_held_valid   = r_held_valid;
        n_rep_idx      = r_rep_idx;
        o_pop          = 1'b0;
        o_wr           = 1'b0;
        o_res          = w_end_res;
        unique case (r_seq)
            S_RUN: begin
                if (i_head.avail && !i_oq_full) begin
                    if ((r_mode == M_MATCH) && (i_head.word.flush || !m_hit)) begin
                        o_wr      = 1'b1;
                        o_res     = w_sign_res;
                        n_mode    = M_IDLE;
                        n_rep_idx = 4'd1;
                        n_seq     = S_REPLAY;
                    end else if (r_mode == M_MATCH) begin
                        o_pop = 1'b1;
                        if (m_done) begin
                            o_wr           = 1'b1;
                            o_res          = '{ch: CH_HASH,
                                               kind: t_kind'(4'(K_STOP) + {2'b00, m_j}),
                                               last: 1'b1, empty: 1'b0};
                            n_mode         = (m_j == 2'd0) ? M_STOPPED : M_SWALLOW;
                            n_match_count  = 4'd0;
                            n_match_branch = 2'd0;
                        end else begin
                            n_match_count  = r_match_count + 4'd1;
                            n_match_branch = m_j;
                        end
                    end else if (i_head.word.flush) begin
                        if ((r_mode == M_SLASH) && (i_sign_char == CH_SLASH)) begin
                            o_wr  = 1'b1;
                            o_res = w_sign_res;
                            n_seq = S_END;
                        end else if ((r_mode == M_WORD) || (r_mode == M_LABEL) ||
                                     (r_mode == M_STRING) || (r_mode == M_ESCAPE)) begin
                            o_wr  = 1'b1;
                            o_res = w_close_res;
                            n_seq = S_END;
                        end else begin
                            o_wr           = 1'b1;
                            o_res          = w_end_res;
                            o_pop          = 1'b1;
                            n_mode         = M_IDLE;
                            n_match_count  = 4'd0;
                            n_match_branch = 2'd0;
                            n_held_char    = 8'h00;
                            n_held_kind    = K_WORD;
                            n_held_valid   = 1'b0;
                        end
                    end else begin
                        o_pop          = 1'b1;
                        o_wr           = p_emit;
                        o_res          = p_res;
                        n_mode         = p_mode;
                        n_match_count  = p_cnt;
                        n_match_branch = p_br;
                        n_held_char    = p_char;
                        n_held_kind    = p_kind;
                        n_held_valid   = p_valid;
                    end
                end
            end
            S_REPLAY: begin
                if (!i_oq_full) begin
                    if (r_rep_idx < r_match_count) begin
                        o_wr           = p_emit;
                        o_res          = p_res;
                        n_mode         = p_mode;
                        n_match_count  = p_cnt;
                        n_match_branch = p_br;
                        n_held_char    = p_char;
                        n_held_kind    = p_kind;
                        n_held_valid   = p_valid;
                        n_rep_idx      = r_rep_idx + 4'd1;
                    end else begin
                        n_seq = S_RUN;
                    end
                end
            end
            default: begin
                if (!i_oq_full) begin
                    o_wr           = 1'b1;
                    o_res          = w_end_res;
                    o_pop          = 1'b1;
                    n_seq          = S_RUN;
                    n_mode         = M_IDLE;
                    n_match_count  = 4'd0;
                    n_match_branch = 2'd0;
                    n_held_char    = 8'h00;
                    n_held_kind    = K_WORD;
                    n_held_valid   = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq          <= S_RUN;
            r_mode         <= M_IDLE;
            r_match_count  <= 4'd0;
            r_match_branch <= 2'd0;
            r_held_char    <= 8'h00;
            r_held_kind    <= K_WORD;
            r_held_valid   <= 1'b0;
            r_rep_idx      <= 4'd0;
        end else begin
            r_seq          <= n_seq;
            r_mode         <= n_mode;
            r_match_count  <= n_match_count;
            r_match_branch <= n_match_branch;
            r_held_char    <= n_held_char;
            r_held_kind    <= n_held_kind;
            r_held_valid   <= n_held_valid;
            r_rep_idx      <= n_rep_idx;
        end
    end

endmodule

### rtl/ttl_outq.sv
// Result queue between the lexer engine and the result port.
`timescale 1ns / 1ps
module ttl_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  ttl_pkg::t_res   i_res,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output ttl_pkg::t_res   o_res
);
    import ttl_pkg::*;

    t_res               r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]   r_wp;
    logic [OQ_AW-1:0]   r_rp;
    logic [OQ_CW-1:0]   r_cnt;
    logic               w_wr;
    logic               w_rd;

    assign o_full  = (r_cnt == OQ_CW'(OQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_mem[r_rp];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_wr && w_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_res;
        end
    end

endmodule

### rtl/template_text_lexer.sv
// Top level of the template text lexer: queues, lexer engine and register port.
//
// Usage:
//   Input words (i_action, i_text_byte) enter on push while full is low; one
//   word is a text byte or, with i_action high, an end-of-text flush.
//   Result words (o_token_char, o_token_kind, o_token_last, o_token_empty)
//   wait while empty is low and leave on pop. Each token is a run of words,
//   the last one marked; a flush ends with one end word.
//   A byte is held in the input queue and its result in the result queue.
//   Throughput: one byte per cycle while the result queue has room and no
//   replay or token-closing flush runs, set by the engine taking one queued
//   word per cycle. A failed directive match emits the sign, relexes the
//   prefix, then the held byte; a closing flush emits its close word first.
//   The result queue holds four words; when it fills because pop stays low,
//   the engine holds and the two-word input queue fills and raises full.
//   sign_char lies at byte address 0 of the APB port; the user must write it
//   only while the block is idle, which the block itself does not enforce.
//   Reset (synchronous, active low) empties both queues, returns the lexer
//   to idle and sets sign_char to '#'.
`timescale 1ns / 1ps
module template_text_lexer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_action,
    input  logic [7:0]                 i_text_byte,
    output logic                       empty,
    input  logic                       pop,
    output logic [7:0]                 o_token_char,
    output logic [3:0]                 o_token_kind,
    output logic                       o_token_last,
    output logic                       o_token_empty,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ttl_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ttl_pkg::*;

    logic [7:0] r_sign_char;
    logic       w_cfg_wr;
    logic       w_sel_sign;
    t_head      w_head;
    logic       w_pop;
    logic       w_wr;
    t_res       w_res;
    logic       w_oq_full;
    t_res       w_out;

    assign pready     = 1'b1;
    assign w_sel_sign = (paddr[APB_AW-1:2] == REG_SIGN_CHAR);
    assign w_cfg_wr   = psel && penable && pwrite && pready && w_sel_sign;
    assign prdata     = w_sel_sign ? {24'h000000, r_sign_char} : 32'h00000000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sign_char <= SIGN_RESET;
        end else if (w_cfg_wr) begin
            r_sign_char <= pwdata[7:0];
        end
    end

    ttl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_action    (i_action),
        .i_text_byte (i_text_byte),
        .o_full      (full),
        .i_pop       (w_pop),
        .o_head      (w_head)
    );

    ttl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sign_char (r_sign_char),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_wr        (w_wr),
        .o_res       (w_res),
        .i_oq_full   (w_oq_full)
    );

    ttl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_res   (w_res),
        .o_full  (w_oq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (w_out)
    );

    assign o_token_char  = w_out.ch;
    assign o_token_kind  = w_out.kind;
    assign o_token_last  = w_out.last;
    assign o_token_empty = w_out.empty;

endmodule

### tb/tb_template_text_lexer.sv
// Self-checking testbench for the template text lexer: token prediction, random stream, APB setup.
`timescale 1ns / 1ps
module tb_template_text_lexer;
    import ttl_pkg::*;

    localparam int TOKENS_PER_BYTE = 12;
    localparam int RANDOM_ITEMS    = 240;
    localparam int SETTLE_CYCLES   = 20;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                push        = 1'b0;
    logic                i_action    = 1'b0;
    logic [7:0]          i_text_byte = 8'h00;
    logic                pop         = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [APB_AW-1:0]   paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic                full;
    logic                empty;
    logic [7:0]          o_token_char;
    logic [3:0]          o_token_kind;
    logic                o_token_last;
    logic                o_token_empty;
    logic [31:0]         prdata;
    logic                pready;

    template_text_lexer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_text_byte   (i_text_byte),
        .empty         (empty),
        .pop           (pop),
        .o_token_char  (o_token_char),
        .o_token_kind  (o_token_kind),
        .o_token_last  (o_token_last),
        .o_token_empty (o_token_empty),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // lexer state mirrored by the predictor
    t_mode      lx_mode;
    logic [3:0] lx_cnt;
    logic [1:0] lx_br;
    logic [7:0] hold_ch;
    t_kind      hold_kind;
    logic       hold_vld;
    logic [7:0] sign_reg;

    t_res pending_tokens[$];
    int   step_n;
    int   errors     = 0;
    int   items_sent = 0;
    bit   calm_mode  = 1'b0;
    int   pop_stall  = 0;

    function automatic int dir_size(input int br);
        string s;
        case (br)
            0: s = "#cxy stop";
            1: s = "#cxy start";
            2: s = "#cxy stob";
            default: s = "#cxy starb";
        endcase
        return s.len();
    endfunction

    function automatic logic [7:0] dir_byte(input int br, input int idx);
        string s;
        case (br)
            0: s = "#cxy stop";
            1: s = "#cxy start";
            2: s = "#cxy stob";
            default: s = "#cxy starb";
        endcase
        return (idx < s.len()) ? s[idx] : 8'h00;
    endfunction

    function automatic bit same_prefix(input int a, input int c, input int k);
        for (int i = 0; i < k; i++) begin
            if (dir_byte(a, i) != dir_byte(c, i)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic bit is_alnum_byte(input logic [7:0] b);
        return is_letter(b) || (b >= "0" && b <= "9");
    endfunction

    function automatic void lex_put(input logic [7:0] ch, input t_kind kind,
                                    input logic last, input logic emp);
        t_res r;
        if (step_n < TOKENS_PER_BYTE) begin
            r.ch    = ch;
            r.kind  = kind;
            r.last  = last;
            r.empty = emp;
            pending_tokens.push_back(r);
            step_n++;
        end
    endfunction

    function automatic void lex_hold(input logic [7:0] b);
        if (hold_vld) lex_put(hold_ch, hold_kind, 1'b0, 1'b0);
        hold_ch  = b;
        hold_vld = 1'b1;
    endfunction

    function automatic void lex_close();
        if (hold_vld) lex_put(hold_ch, hold_kind, 1'b1, 1'b0);
        else lex_put(8'h00, hold_kind, 1'b1, 1'b1);
        hold_vld = 1'b0;
    endfunction

    function automatic void lex_open(input t_kind kind, input t_mode mode);
        hold_kind = kind;
        hold_vld  = 1'b0;
        lx_mode   = mode;
    endfunction

    function automatic void lex_clear();
        lx_mode   = M_IDLE;
        lx_cnt    = '0;
        lx_br     = '0;
        hold_ch   = '0;
        hold_kind = K_WORD;
        hold_vld  = 1'b0;
    endfunction

    function automatic void lex_idle(input logic [7:0] b);
        lx_mode = M_IDLE;
        if (b == CH_SLASH) begin
            lx_mode = M_SLASH;
        end else if (is_alnum_byte(b)) begin
            lex_open(K_WORD, M_WORD);
            lex_hold(b);
        end else if (b == CH_QUOTE) begin
            lex_open(K_STRING, M_STRING);
        end else if (b == sign_reg) begin
            if (b == CH_HASH) begin
                lx_mode = M_MATCH;
                lx_cnt  = 4'd1;
                lx_br   = '0;
            end else begin
                lex_put(CH_HASH, K_SIGN, 1'b1, 1'b0);
            end
        end else if (b == CH_COLON) begin
            lex_open(K_LABEL, M_LABEL);
            lex_hold(b);
        end
    endfunction

    function automatic void lex_plain(input logic [7:0] b);
        bit keep;
        case (lx_mode)
            M_SLASH: begin
                lx_mode = M_IDLE;
                if (b == CH_SLASH) begin
                    lx_mode = M_COMMENT;
                end else begin
                    if (sign_reg == CH_SLASH) lex_put(CH_HASH, K_SIGN, 1'b1, 1'b0);
                    lex_idle(b);
                end
            end
            M_COMMENT: begin
                if (b == CH_NL) lex_idle(b);
            end
            M_WORD, M_LABEL: begin
                keep = (lx_mode == M_WORD) ? is_alnum_byte(b) : is_letter(b);
                if (keep) begin
                    lex_hold(b);
                end else begin
                    lex_close();
                    lx_mode = M_IDLE;
                end
            end
            M_STRING: begin
                if (b == CH_QUOTE) begin
                    lex_close();
                    lx_mode = M_IDLE;
                end else begin
                    lex_hold(b);
                    if (b == CH_BSLASH) lx_mode = M_ESCAPE;
                end
            end
            M_ESCAPE: begin
                lex_hold(b);
                lx_mode = M_STRING;
            end
            M_SWALLOW: begin
                lx_mode = M_IDLE;
            end
            M_STOPPED: begin
            end
            default: begin
                lex_idle(b);
            end
        endcase
    endfunction

    // drop the match: emit the sign and relex the buffered directive prefix
    function automatic void lex_fail();
        int br;
        int k;
        br = lx_br;
        k  = lx_cnt;
        if (k > dir_size(br)) k = dir_size(br);
        lx_mode = M_IDLE;
        lex_put(CH_HASH, K_SIGN, 1'b1, 1'b0);
        for (int i = 1; i < k; i++) lex_plain(dir_byte(br, i));
    endfunction

    function automatic void lex_feed(input logic [7:0] b);
        int   br;
        int   k;
        int   hit;
        logic done;
        done = 1'b0;
        if (lx_mode == M_MATCH) begin
            br = lx_br;
            k  = lx_cnt;
            if (k > dir_size(br)) k = dir_size(br);
            hit = -1;
            for (int j = 0; j < 4; j++) begin
                if (hit < 0 && k < dir_size(j) && same_prefix(j, br, k) &&
                    dir_byte(j, k) == b) hit = j;
            end
            if (hit >= 0) begin
                done = 1'b1;
                if (k + 1 == dir_size(hit)) begin
                    lex_put(CH_HASH, t_kind'(K_STOP + hit), 1'b1, 1'b0);
                    lx_mode = (hit == 0) ? M_STOPPED : M_SWALLOW;
                    lx_cnt  = '0;
                    lx_br   = '0;
                end else begin
                    lx_cnt = 4'(k + 1);
                    lx_br  = 2'(hit);
                end
            end else begin
                lex_fail();
            end
        end
        if (!done) lex_plain(b);
    endfunction

    function automatic void lex_flush();
        if (lx_mode == M_MATCH) lex_fail();
        case (lx_mode)
            M_SLASH: begin
                if (sign_reg == CH_SLASH) lex_put(CH_HASH, K_SIGN, 1'b1, 1'b0);
            end
            M_WORD, M_LABEL, M_STRING, M_ESCAPE: begin
                lex_close();
            end
            default: begin
            end
        endcase
        lex_put(8'h00, K_END, 1'b1, 1'b1);
        lex_clear();
    endfunction

    function automatic void predict_tokens(input logic act, input logic [7:0] b);
        step_n = 0;
        if (act) lex_flush();
        else lex_feed(b);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_mode || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_alnum();
        string set;
        set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_letter();
        string set;
        set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic check_token();
        t_res exp;
        if (pending_tokens.size() == 0) begin
            errors++;
            $display("%0t: unexpected word char %02h kind %0d last %0b empty %0b", $time,
                     o_token_char, o_token_kind, o_token_last, o_token_empty);
        end else begin
            exp = pending_tokens.pop_front();
            if (exp.ch !== o_token_char) begin
                errors++;
                $display("%0t: token_char expected %02h actual %02h", $time,
                         exp.ch, o_token_char);
            end
            if (4'(exp.kind) !== o_token_kind) begin
                errors++;
                $display("%0t: token_kind expected %0d actual %0d", $time,
                         exp.kind, o_token_kind);
            end
            if (exp.last !== o_token_last) begin
                errors++;
                $display("%0t: token_last expected %0b actual %0b", $time,
                         exp.last, o_token_last);
            end
            if (exp.empty !== o_token_empty) begin
                errors++;
                $display("%0t: token_empty expected %0b actual %0b", $time,
                         exp.empty, o_token_empty);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && !empty && pop) check_token();
        if (pop_stall > 0) begin
            pop_stall--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            if (!calm_mode) begin
                if ($urandom_range(0, 99) < 12) pop_stall = $urandom_range(1, 3);
                else if ($urandom_range(0, 99) < 3) pop_stall = $urandom_range(10, 40);
            end
        end
    end

    task automatic send_word(input logic act, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_action    <= act;
        i_text_byte <= b;
        do @(posedge i_clk); while (full);
        predict_tokens(act, b);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
    endtask

    task automatic send_flush();
        send_word(1'b1, 8'h00);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sign(input logic [7:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SIGN_CHAR, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        sign_reg = value;
        @(posedge i_clk);
    endtask

    task automatic test_basic_tokens();
        send_text("ab9 ");
        send_text("\"\\\"x\"");
        send_text("\"\"");
        send_text(":q.");
        send_text("/x ");
        send_text("//z\n");
        send_text("#c!");
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h80);
        send_word(1'b0, 8'h00);
        send_text("Z");
        send_flush();
    endtask

    task automatic test_directives();
        for (int br = 1; br < 4; br++) begin
            for (int i = 0; i < dir_size(br); i++) send_word(1'b0, dir_byte(br, i));
            send_text("A");
        end
        send_text("#cxy sta");
        send_flush();
        send_text("#cxy stoX");
        send_text("#cxy \"q");
        send_flush();
        for (int i = 0; i < dir_size(0); i++) send_word(1'b0, dir_byte(0, i));
        send_text("ab:\"");
        send_flush();
    endtask

    task automatic test_sign_register();
        write_sign(CH_SLASH);
        send_text("/a/ //c\n/");
        send_flush();
        write_sign("a");
        send_text("ab#a");
        send_flush();
        write_sign(8'hFF);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h7F);
        send_flush();
        write_sign(8'h00);
        send_text("x");
        send_word(1'b0, 8'h00);
        send_flush();
        write_sign(CH_COLON);
        send_text(":ab:");
        send_flush();
        write_sign(SIGN_RESET);
    endtask

    task automatic send_piece();
        int n;
        int br;
        int k;
        case ($urandom_range(0, 11))
            0, 1: begin
                n = $urandom_range(1, 6);
                repeat (n) send_word(1'b0, pick_alnum());
                send_word(1'b0, pick_byte());
            end
            2: begin
                send_word(1'b0, CH_QUOTE);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_word(1'b0, CH_BSLASH);
                        send_word(1'b0, $urandom_range(0, 1) ? CH_QUOTE : pick_byte());
                    end else begin
                        send_word(1'b0, $urandom_range(0, 1) ? pick_alnum() : pick_byte());
                    end
                end
                if ($urandom_range(0, 4) != 0) send_word(1'b0, CH_QUOTE);
            end
            3: begin
                send_word(1'b0, CH_COLON);
                n = $urandom_range(0, 4);
                repeat (n) send_word(1'b0, pick_letter());
                send_word(1'b0, pick_byte());
            end
            4: begin
                send_word(1'b0, CH_SLASH);
                send_word(1'b0, CH_SLASH);
                n = $urandom_range(0, 4);
                repeat (n) send_word(1'b0, pick_byte());
                send_word(1'b0, CH_NL);
            end
            5, 6: begin
                br = $urandom_range(0, 3);
                if ($urandom_range(0, 2) != 0) begin
                    for (int i = 0; i < dir_size(br); i++) send_word(1'b0, dir_byte(br, i));
                    if (br == 0) begin
                        n = $urandom_range(0, 3);
                        repeat (n) send_word(1'b0, pick_byte());
                        send_flush();
                    end else begin
                        send_word(1'b0, pick_byte());
                    end
                end else begin
                    k = $urandom_range(1, dir_size(br) - 1);
                    for (int i = 0; i < k; i++) send_word(1'b0, dir_byte(br, i));
                    send_word(1'b0, $urandom_range(0, 1) ? pick_alnum() : pick_byte());
                end
            end
            7: begin
                send_word(1'b0, CH_SLASH);
                send_word(1'b0, pick_byte());
            end
            8: begin
                send_word(1'b0, sign_reg);
                send_word(1'b0, pick_byte());
            end
            9: begin
                n = $urandom_range(1, 3);
                repeat (n) send_word(1'b0, pick_byte());
            end
            10: begin
                send_flush();
            end
            default: begin
                send_text($urandom_range(0, 1) ? " " : "\n");
            end
        endcase
    endtask

    task automatic test_random_stream();
        logic [7:0] sign_val;
        int         goal;
        int         mid;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                2: sign_val = CH_SLASH;
                3: sign_val = CH_COLON;
                4: sign_val = pick_byte();
                default: sign_val = SIGN_RESET;
            endcase
            write_sign(sign_val);
            calm_mode = (ph == 1);
            goal = items_sent + RANDOM_ITEMS / 6;
            mid  = items_sent + RANDOM_ITEMS / 12;
            while (items_sent < goal) begin
                send_piece();
                if (ph == 0 && items_sent >= mid) begin
                    drain_results();
                    mid = goal;
                end
            end
            send_flush();
            calm_mode = 1'b0;
        end
        write_sign(SIGN_RESET);
    endtask

    initial begin
        sign_reg = SIGN_RESET;
        lex_clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_tokens();
        test_directives();
        test_sign_register();
        test_random_stream();
        drain_results();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### template_text_lexer.f
rtl/ttl_pkg.sv
rtl/ttl_front.sv
rtl/ttl_back.sv
rtl/ttl_outq.sv
rtl/template_text_lexer.sv
tb/tb_template_text_lexer.sv
